/* rtl/ftd_pkg.sv */
`default_nettype none
package ftd_pkg;

  // One sensor tick
  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] vertical_accel_cms;
    logic signed [15:0] roll_cdeg;
    logic signed [15:0] pitch_cdeg;
    logic               flip_active;
    logic               rc_locked;
    logic               flight_armed;
    logic               mode_low_bit;
  } ftd_in_t;

  typedef struct packed {
    logic freefall_detected;
    logic tumble_detected;
  } ftd_out_t;

  typedef struct packed {
    logic [31:0] mag_thr;
    logic [15:0] vert_thr;
    logic [15:0] ff_persist;
    logic [14:0] tilt_thr;
    logic [15:0] tu_persist;
    logic [15:0] holdoff_ticks;
  } ftd_cfg_t;

  // Squares and early compares, handed from the prep stage to the tracker
  typedef struct packed {
    logic [30:0] sq_x;
    logic [30:0] sq_y;
    logic [30:0] sq_z;
    logic        vert_ok;
    logic        tilt_over;
    logic        flip;
    logic        ff_enable;
  } ftd_prep_t;

  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAG_THR       = 3'd0,
    REG_VERT_THR      = 3'd1,
    REG_FF_PERSIST    = 3'd2,
    REG_TILT_THR      = 3'd3,
    REG_TU_PERSIST    = 3'd4,
    REG_HOLDOFF_TICKS = 3'd5
  } ftd_reg_t;

  localparam logic [31:0] MAG_THR_RST       = 32'd838861;
  localparam logic [15:0] VERT_THR_RST      = 16'd49;
  localparam logic [15:0] FF_PERSIST_RST    = 16'd30;
  localparam logic [14:0] TILT_THR_RST      = 15'd6000;
  localparam logic [15:0] TU_PERSIST_RST    = 16'd100;
  localparam logic [15:0] HOLDOFF_TICKS_RST = 16'd1000;

  localparam logic signed [16:0] G_BIAS_CMS = 17'sd980;
  localparam logic [15:0]        COUNT_MAX  = 16'hFFFF;

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    logic [15:0] t;
    t = v[15] ? 16'(-v) : 16'(v);
    return t;
  endfunction

  function automatic logic [15:0] abs17(input logic signed [16:0] v);
    logic [16:0] t;
    t = v[16] ? 17'(-v) : 17'(v);
    return t[15:0];
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] c);
    return (c == COUNT_MAX) ? COUNT_MAX : c + 16'd1;
  endfunction

endpackage
`default_nettype wire

/* rtl/ftd_prep.sv */
`default_nettype none
module ftd_prep import ftd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      load,
  input  wire ftd_in_t   d,
  input  wire ftd_cfg_t  cfg,
  output ftd_prep_t      q
);

  logic signed [31:0] px, py, pz;
  logic signed [16:0] vsum;
  logic [15:0]        vdev, r_abs, p_abs, tilt;
  ftd_prep_t          q_next;

  always_comb begin
    px   = d.accel_x * d.accel_x;
    py   = d.accel_y * d.accel_y;
    pz   = d.accel_z * d.accel_z;
    vsum = {d.vertical_accel_cms[15], d.vertical_accel_cms} + G_BIAS_CMS;
    vdev = abs17(vsum);
    r_abs = abs16(d.roll_cdeg);
    p_abs = abs16(d.pitch_cdeg);
    tilt  = (r_abs >= p_abs) ? r_abs : p_abs;

    q_next.sq_x      = px[30:0];
    q_next.sq_y      = py[30:0];
    q_next.sq_z      = pz[30:0];
    q_next.vert_ok   = vdev < cfg.vert_thr;
    q_next.tilt_over = tilt > {1'b0, cfg.tilt_thr};
    q_next.flip      = d.flip_active;
    q_next.ff_enable = !d.rc_locked && !d.flight_armed && d.mode_low_bit;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= q_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/ftd_track.sv */
`default_nettype none
module ftd_track import ftd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire ftd_cfg_t  cfg,
  input  wire logic      take,
  input  wire ftd_prep_t p,
  input  wire logic      out_take,
  output logic           out_valid,
  output ftd_out_t       out_data
);

  logic [15:0] freefall_count, freefall_count_next;
  logic [15:0] tumble_count, tumble_count_next;
  logic [15:0] flip_holdoff, flip_holdoff_next;
  logic [15:0] ff_inc, tu_inc;
  logic [31:0] mag;
  logic        mag_ok;
  ftd_out_t    res;

  always_comb begin
    mag    = {1'b0, p.sq_x} + {1'b0, p.sq_y} + {1'b0, p.sq_z};
    mag_ok = mag < cfg.mag_thr;
    ff_inc = sat_inc(freefall_count);
    tu_inc = sat_inc(tumble_count);

    freefall_count_next = freefall_count;
    tumble_count_next   = tumble_count;
    flip_holdoff_next   = flip_holdoff;
    res                 = '0;

    if (p.flip) begin
      flip_holdoff_next = cfg.holdoff_ticks;
    end else begin
      if (p.ff_enable) begin
        if (mag_ok && p.vert_ok) begin
          freefall_count_next   = ff_inc;
          res.freefall_detected = ff_inc >= cfg.ff_persist;
        end else begin
          freefall_count_next = '0;
        end
      end
      if (flip_holdoff != '0) begin
        flip_holdoff_next = flip_holdoff - 16'd1;
      end
      // tumble test runs only once the holdoff has drained
      if (flip_holdoff_next == '0) begin
        if (p.tilt_over) begin
          tumble_count_next   = tu_inc;
          res.tumble_detected = tu_inc >= cfg.tu_persist;
        end else begin
          tumble_count_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freefall_count <= '0;
      tumble_count   <= '0;
      flip_holdoff   <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (take) begin
        freefall_count <= freefall_count_next;
        tumble_count   <= tumble_count_next;
        flip_holdoff   <= flip_holdoff_next;
        out_valid      <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

/* rtl/freefall_tumble_detector_core.sv */
`default_nettype none
// Free-fall and tumble detector, three register stages: input, squares, result.
// Each accepted input word passes through the input, squares and result registers in that order.
// Throughput: one word per cycle while out_ready holds; stages advance independently on ready.
// Reset (rst, synchronous): counters and holdoff cleared, pipeline emptied,
// configuration registers back to their default thresholds.
module freefall_tumble_detector_core import ftd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ftd_in_t            in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ftd_out_t                out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [31:0]        cfg_data
);

  ftd_cfg_t  cfg;
  ftd_in_t   a_data;
  logic      a_valid, b_valid;
  logic      ready_b, ready_c, a_take, b_take, out_take;
  ftd_prep_t b_data;

  assign cfg_ready = 1'b1;
  assign out_take  = out_valid && out_ready;
  assign ready_c   = !out_valid || out_ready;
  assign b_take    = b_valid && ready_c;
  assign ready_b   = !b_valid || ready_c;
  assign a_take    = a_valid && ready_b;
  assign in_ready  = !a_valid || ready_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mag_thr       <= MAG_THR_RST;
      cfg.vert_thr      <= VERT_THR_RST;
      cfg.ff_persist    <= FF_PERSIST_RST;
      cfg.tilt_thr      <= TILT_THR_RST;
      cfg.tu_persist    <= TU_PERSIST_RST;
      cfg.holdoff_ticks <= HOLDOFF_TICKS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAG_THR:       cfg.mag_thr       <= cfg_data;
        REG_VERT_THR:      cfg.vert_thr      <= cfg_data[15:0];
        REG_FF_PERSIST:    cfg.ff_persist    <= cfg_data[15:0];
        REG_TILT_THR:      cfg.tilt_thr      <= cfg_data[14:0];
        REG_TU_PERSIST:    cfg.tu_persist    <= cfg_data[15:0];
        REG_HOLDOFF_TICKS: cfg.holdoff_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        a_valid <= 1'b1;
      end else if (a_take) begin
        a_valid <= 1'b0;
      end
      if (a_take) begin
        b_valid <= 1'b1;
      end else if (b_take) begin
        b_valid <= 1'b0;
      end
    end
  end

  // hold the input word until the squares stage takes it
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_data <= in_data;
    end
  end

  ftd_prep u_prep (
    .clk  (clk),
    .load (a_take),
    .d    (a_data),
    .cfg  (cfg),
    .q    (b_data)
  );

  ftd_track u_track (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (b_take),
    .p         (b_data),
    .out_take  (out_take),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* tb/freefall_tumble_detector_core_tb.sv */
`timescale 1ns / 1ps
module freefall_tumble_detector_core_tb;
  import ftd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int LONG_HOLD = 400;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_TICKS = 180;
  localparam int SOAK_TICKS = 120;
  localparam int GRAVITY_CMS = 980;
  localparam logic [15:0] RUN_MAX = 16'hFFFF;
  localparam logic [CfgIdxW-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] IDX_SPARE_HI = 3'd7;
  localparam bit KNOWN = 1'b1;
  localparam bit CALC = 1'b0;

  typedef enum logic {ROW_TICK, ROW_REG} row_kind_e;
  typedef enum int {BURST_FALL, BURST_TILT, BURST_NOISE} burst_e;

  typedef struct {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [31:0]        val;
    ftd_in_t            tick;
    bit                 typed;
    ftd_out_t           flags;
  } script_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  ftd_in_t            in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  ftd_out_t           out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  // Predictor copy of the thresholds and counters
  ftd_cfg_t    limits;
  logic [15:0] fall_run;
  logic [15:0] tilt_run;
  logic [15:0] holdoff_left;

  ftd_out_t    pending_flags[$];
  script_row_t script[$];
  int          mismatches = 0;
  int          results_seen = 0;
  bit          no_idle = 1'b0;
  bit          hold_off_req = 1'b0;

  freefall_tumble_detector_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int srange(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Mostly back-to-back, sometimes a short gap, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    case (idx)
      REG_MAG_THR:       limits.mag_thr = val;
      REG_VERT_THR:      limits.vert_thr = val[15:0];
      REG_FF_PERSIST:    limits.ff_persist = val[15:0];
      REG_TILT_THR:      limits.tilt_thr = val[14:0];
      REG_TU_PERSIST:    limits.tu_persist = val[15:0];
      REG_HOLDOFF_TICKS: limits.holdoff_ticks = val[15:0];
      default: ;
    endcase
  endfunction

  function automatic ftd_out_t predict_flags(input ftd_in_t t);
    logic signed [31:0] ax, ay, az;
    logic [31:0]        mag;
    logic signed [16:0] vsum, rs, ps;
    logic [16:0]        vdev, ra, pa, tilt;
    ftd_out_t           res;
    res = '0;
    if (t.flip_active) begin
      holdoff_left = limits.holdoff_ticks;
      return res;
    end
    if (!t.rc_locked && !t.flight_armed && t.mode_low_bit) begin
      ax = t.accel_x;
      ay = t.accel_y;
      az = t.accel_z;
      // sum of squares tops out at 3 * 2^30, so 32 bits hold it exactly
      mag = ax * ax + ay * ay + az * az;
      vsum = 17'(t.vertical_accel_cms) + 17'(GRAVITY_CMS);
      vdev = vsum[16] ? 17'(-vsum) : 17'(vsum);
      if (mag < limits.mag_thr && vdev < 17'(limits.vert_thr)) begin
        fall_run = (fall_run == RUN_MAX) ? RUN_MAX : fall_run + 16'd1;
        res.freefall_detected = (fall_run >= limits.ff_persist);
      end else begin
        fall_run = '0;
      end
    end
    if (holdoff_left != 16'd0) holdoff_left = holdoff_left - 16'd1;
    if (holdoff_left == 16'd0) begin
      rs = 17'(t.roll_cdeg);
      ps = 17'(t.pitch_cdeg);
      ra = rs[16] ? 17'(-rs) : 17'(rs);
      pa = ps[16] ? 17'(-ps) : 17'(ps);
      tilt = (ra >= pa) ? ra : pa;
      if (tilt > 17'(limits.tilt_thr)) begin
        tilt_run = (tilt_run == RUN_MAX) ? RUN_MAX : tilt_run + 16'd1;
        res.tumble_detected = (tilt_run >= limits.tu_persist);
      end else begin
        tilt_run = '0;
      end
    end
    return res;
  endfunction

  function automatic ftd_in_t random_tick(input burst_e kind);
    ftd_in_t t;
    int      vspan, thr, a;
    t = '0;
    thr = int'(limits.tilt_thr);
    vspan = (limits.vert_thr > 16'd150) ? 150 : int'(limits.vert_thr) + 2;
    t.rc_locked = ($urandom_range(0, 29) == 0);
    t.flight_armed = ($urandom_range(0, 29) == 0);
    t.mode_low_bit = ($urandom_range(0, 29) != 0);
    t.accel_x = 16'(srange(-512, 511));
    t.accel_y = 16'(srange(-512, 511));
    t.accel_z = 16'(srange(-512, 511));
    t.vertical_accel_cms = 16'(srange(-vspan, vspan) - GRAVITY_CMS);
    t.roll_cdeg = 16'(srange(-18000, 18000));
    t.pitch_cdeg = 16'(srange(-18000, 18000));
    case (kind)
      BURST_TILT: begin
        // one axis hovers at the tilt limit, the other stays within it
        a = thr + srange(-4, 4);
        if (a < 0) a = 0;
        if (a > 18000) a = 18000;
        if ($urandom_range(0, 1)) a = -a;
        if ($urandom_range(0, 1)) begin
          t.roll_cdeg = 16'(a);
          t.pitch_cdeg = 16'(srange(-thr, thr));
        end else begin
          t.pitch_cdeg = 16'(a);
          t.roll_cdeg = 16'(srange(-thr, thr));
        end
      end
      BURST_NOISE: begin
        t.accel_x = 16'($urandom());
        t.accel_y = 16'($urandom());
        t.accel_z = 16'($urandom());
        t.vertical_accel_cms = 16'($urandom());
        t.rc_locked = 1'($urandom_range(0, 1));
        t.flight_armed = 1'($urandom_range(0, 1));
        t.mode_low_bit = 1'($urandom_range(0, 1));
      end
      default: ;
    endcase
    t.flip_active = ($urandom_range(0, 32) == 0);
    return t;
  endfunction

  task automatic add_tick(input int ax, input int ay, input int az, input int vz,
                          input int roll, input int pitch, input bit flip, input bit lock,
                          input bit armed, input bit mode, input bit typed,
                          input logic [1:0] want);
    script_row_t r;
    r.kind = ROW_TICK;
    r.idx = '0;
    r.val = '0;
    r.tick.accel_x = 16'(ax);
    r.tick.accel_y = 16'(ay);
    r.tick.accel_z = 16'(az);
    r.tick.vertical_accel_cms = 16'(vz);
    r.tick.roll_cdeg = 16'(roll);
    r.tick.pitch_cdeg = 16'(pitch);
    r.tick.flip_active = flip;
    r.tick.rc_locked = lock;
    r.tick.flight_armed = armed;
    r.tick.mode_low_bit = mode;
    r.typed = typed;
    r.flags = want;
    script.push_back(r);
  endtask

  task automatic add_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    script_row_t r;
    r.kind = ROW_REG;
    r.idx = idx;
    r.val = val;
    r.tick = '0;
    r.typed = CALC;
    r.flags = '0;
    script.push_back(r);
  endtask

  task automatic send_tick(input ftd_in_t t, input bit typed, input ftd_out_t want);
    int       gap;
    ftd_out_t guess;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    guess = predict_flags(t);
    pending_flags.push_back(typed ? want : guess);
  endtask

  // Write only once the pipeline has drained
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    ftd_out_t want_flags;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_flags.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, got ff=%0b tu=%0b", $time,
                 out_data.freefall_detected, out_data.tumble_detected);
      end else begin
        want_flags = pending_flags.pop_front();
        if (out_data.freefall_detected !== want_flags.freefall_detected) begin
          mismatches++;
          $display("%0t: freefall_detected expected %0b, got %0b", $time,
                   want_flags.freefall_detected, out_data.freefall_detected);
        end
        if (out_data.tumble_detected !== want_flags.tumble_detected) begin
          mismatches++;
          $display("%0t: tumble_detected expected %0b, got %0b", $time,
                   want_flags.tumble_detected, out_data.tumble_detected);
        end
      end
    end
  end

  initial begin : result_sink
    int hold;
    wait (!rst);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = LONG_HOLD;
      end else begin
        hold = no_idle ? 0 : pick_gap();
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (!rst);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("freefall_tumble_detector_core_tb: errors");
    $finish;
  end

  initial begin : stimulus
    int          ph, sent, run;
    burst_e      kind;
    ftd_in_t     t;
    script_row_t r;
    logic [31:0] mag_v, vert_v, ffp_v, tilt_v, tup_v, hold_v;

    limits = '{mag_thr: 32'd838861, vert_thr: 16'd49, ff_persist: 16'd30,
               tilt_thr: 15'd6000, tu_persist: 16'd100, holdoff_ticks: 16'd1000};
    fall_run = '0;
    tilt_run = '0;
    holdoff_left = '0;

    // thresholds as they come out of reset
    add_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, KNOWN, 2'b00);
    add_tick(-32768, -32768, -32768, 32767, 18000, -18000, 0, 0, 0, 1, KNOWN, 2'b00);
    add_tick(32767, 32767, 32767, -32768, -18000, 18000, 0, 1, 1, 1, KNOWN, 2'b00);
    add_tick(-32768, 32767, -1, 0, 18000, 18000, 1, 1, 1, 1, KNOWN, 2'b00);
    // zero persistence: flags rise on the first qualifying tick
    add_reg(REG_FF_PERSIST, 32'd0);
    add_reg(REG_TU_PERSIST, 32'd0);
    add_reg(REG_HOLDOFF_TICKS, 32'd0);
    add_reg(REG_MAG_THR, 32'hFFFF_FFFF);
    add_reg(REG_VERT_THR, 32'h0000_FFFF);
    add_reg(REG_TILT_THR, 32'd0);
    add_tick(0, 0, 0, -980, 0, 0, 1, 0, 0, 1, KNOWN, 2'b00);
    add_tick(0, 0, 0, -980, 1, 0, 0, 0, 0, 1, KNOWN, 2'b11);
    add_tick(0, 0, 0, -980, 0, 0, 0, 0, 0, 1, KNOWN, 2'b10);
    add_tick(0, 0, 0, -980, 0, -1, 0, 1, 0, 1, KNOWN, 2'b01);
    add_tick(-32768, -32768, -32768, 32767, 0, -18000, 0, 0, 0, 1, KNOWN, 2'b11);
    add_tick(0, 0, 0, -980, 0, 0, 0, 0, 1, 1, KNOWN, 2'b00);
    // zero thresholds: nothing can fall
    add_reg(REG_MAG_THR, 32'd0);
    add_reg(REG_VERT_THR, 32'd0);
    add_tick(0, 0, 0, -980, 18000, 0, 0, 0, 0, 1, KNOWN, 2'b01);
    // upper bits of narrow registers drop; spare indexes do nothing
    add_reg(REG_MAG_THR, 32'd838861);
    add_reg(REG_VERT_THR, 32'hABCD_0031);
    add_reg(REG_FF_PERSIST, 32'hFFFF_0003);
    add_reg(REG_TILT_THR, 32'hFFFF_9770);
    add_reg(REG_TU_PERSIST, 32'h0001_0002);
    add_reg(REG_HOLDOFF_TICKS, 32'h1234_0003);
    add_reg(IDX_SPARE_LO, 32'd0);
    add_reg(IDX_SPARE_HI, 32'hFFFF_FFFF);
    add_tick(0, 0, 0, -932, 0, 0, 0, 0, 0, 1, CALC, 2'b00);
    add_tick(256, -256, 256, -1028, 0, 0, 0, 0, 0, 1, CALC, 2'b00);
    add_tick(0, 0, 0, -980, 0, 0, 0, 0, 0, 1, CALC, 2'b00);
    add_tick(0, 0, 0, -931, 0, 0, 0, 0, 0, 1, CALC, 2'b00);
    add_tick(915, 40, 5, -980, 0, 0, 0, 0, 0, 1, CALC, 2'b00);
    add_tick(915, 40, 6, -980, 0, 0, 0, 0, 0, 1, CALC, 2'b00);
    add_tick(0, 0, 0, 0, 9000, 0, 1, 0, 0, 1, CALC, 2'b00);
    add_tick(0, 0, 0, 0, 9000, 0, 0, 0, 0, 0, CALC, 2'b00);
    add_tick(0, 0, 0, 0, -9000, 0, 0, 0, 0, 0, CALC, 2'b00);
    add_tick(0, 0, 0, 0, 0, 6001, 0, 0, 0, 0, CALC, 2'b00);
    add_tick(0, 0, 0, 0, 6000, -6001, 0, 0, 0, 0, CALC, 2'b00);
    add_tick(0, 0, 0, 0, 6000, -6000, 0, 0, 0, 0, CALC, 2'b00);
    add_tick(-915, -40, -5, -980, 0, 0, 0, 0, 0, 1, CALC, 2'b00);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      r = script[i];
      if (r.kind == ROW_REG)
        write_reg(r.idx, r.val);
      else
        send_tick(r.tick, r.typed, r.flags);
    end

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) begin
        mag_v = 32'd0;
        vert_v = 32'd0;
        ffp_v = 32'd1;
        tilt_v = 32'd0;
        tup_v = 32'd1;
        hold_v = 32'd0;
      end else if (ph == 1) begin
        mag_v = 32'hFFFF_FFFF;
        vert_v = 32'h0000_FFFF;
        ffp_v = 32'h0000_FFFF;
        tilt_v = 32'd18000;
        tup_v = 32'h0000_FFFF;
        hold_v = 32'h0000_FFFF;
      end else begin
        case ($urandom_range(0, 2))
          0:       mag_v = $urandom_range(100000, 900000);
          1:       mag_v = 32'd838861;
          default: mag_v = $urandom();
        endcase
        vert_v = $urandom_range(0, 120);
        ffp_v = $urandom_range(1, 8);
        tilt_v = $urandom_range(0, 18000);
        tup_v = $urandom_range(1, 8);
        hold_v = $urandom_range(0, 20);
      end
      write_reg(REG_MAG_THR, mag_v);
      write_reg(REG_VERT_THR, vert_v);
      write_reg(REG_FF_PERSIST, ffp_v);
      write_reg(REG_TILT_THR, tilt_v);
      write_reg(REG_TU_PERSIST, tup_v);
      write_reg(REG_HOLDOFF_TICKS, hold_v);
      no_idle = (ph == 3);
      sent = 0;
      while (sent < PHASE_TICKS) begin
        run = $urandom_range(0, 99);
        kind = (run < 55) ? BURST_FALL : (run < 85) ? BURST_TILT : BURST_NOISE;
        run = $urandom_range(1, 12);
        repeat (run) begin
          t = random_tick(kind);
          send_tick(t, CALC, '0);
          sent++;
          // stall the result side long enough to back up the input
          if (ph == 2 && sent == 20) hold_off_req = 1'b1;
        end
      end
    end

    // long qualifying run with both persistence limits at their top
    write_reg(REG_MAG_THR, 32'hFFFF_FFFF);
    write_reg(REG_VERT_THR, 32'h0000_FFFF);
    write_reg(REG_FF_PERSIST, 32'h0000_FFFF);
    write_reg(REG_TILT_THR, 32'd0);
    write_reg(REG_TU_PERSIST, 32'h0000_FFFF);
    write_reg(REG_HOLDOFF_TICKS, 32'd0);
    no_idle = 1'b1;
    repeat (SOAK_TICKS) begin
      t = '0;
      t.accel_x = 16'($urandom());
      t.accel_y = 16'($urandom());
      t.accel_z = 16'($urandom());
      t.vertical_accel_cms = 16'($urandom());
      t.roll_cdeg = 16'(srange(1, 18000));
      if ($urandom_range(0, 1)) t.roll_cdeg = -t.roll_cdeg;
      t.pitch_cdeg = 16'(srange(-18000, 18000));
      t.mode_low_bit = 1'b1;
      send_tick(t, CALC, '0);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("freefall_tumble_detector_core_tb: clean");
    else
      $display("freefall_tumble_detector_core_tb: errors");
    $finish;
  end

endmodule

/* sim.f */
rtl/ftd_pkg.sv
rtl/ftd_prep.sv
rtl/ftd_track.sv
rtl/freefall_tumble_detector_core.sv
tb/freefall_tumble_detector_core_tb.sv
